/* design/esc_pkg.sv */
// Package for the epoch-seconds to calendar converter: state codes, time
// constants, the subtractor result type and the month length table.
// No dependencies.
`default_nettype none
package esc_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned OFFSET_W = 17;

  localparam logic [TIME_W-1:0] MIN_SECS     = 32'd60;
  localparam logic [TIME_W-1:0] HOUR_SECS    = 32'd3600;
  localparam logic [TIME_W-1:0] DAY_SECS     = 32'd86400;
  localparam logic [TIME_W-1:0] DAYS28_SECS  = 32'd2419200;
  localparam logic [TIME_W-1:0] DAYS29_SECS  = 32'd2505600;
  localparam logic [TIME_W-1:0] DAYS30_SECS  = 32'd2592000;
  localparam logic [TIME_W-1:0] DAYS31_SECS  = 32'd2678400;
  localparam logic [TIME_W-1:0] YEAR365_SECS = 32'd31536000;
  localparam logic [TIME_W-1:0] YEAR366_SECS = 32'd31622400;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 17'd10800;

  // Register indexes.
  localparam logic REG_ZONE_OFFSET = 1'b0;

  typedef enum logic [2:0] {
    ESC_IDLE,
    ESC_YEAR,
    ESC_MONTH,
    ESC_DAY,
    ESC_HOUR,
    ESC_MIN
  } esc_state_t;

  typedef struct packed {
    logic              ge;
    logic [TIME_W-1:0] diff;
  } esc_sub_t;

  // Length of a month in seconds; leap means the two-digit year is a multiple of 4.
  function automatic logic [TIME_W-1:0] month_span(input logic [3:0] mon, input logic leap);
    logic [TIME_W-1:0] span;
    if (mon == 4'd2) begin
      span = leap ? DAYS29_SECS : DAYS28_SECS;
    end else if ((mon[0] && mon < 4'd8) || (!mon[0] && mon > 4'd7)) begin
      span = DAYS31_SECS;
    end else begin
      span = DAYS30_SECS;
    end
    return span;
  endfunction

endpackage
`default_nettype wire

/* design/esc_sub_unit.sv */
// Shared compare-and-subtract unit of the calendar converter.
// Depends on esc_pkg.
`default_nettype none
module esc_sub_unit
  import esc_pkg::*;
(
  input  wire logic [TIME_W-1:0] a,
  input  wire logic [TIME_W-1:0] b,
  output esc_sub_t               res
);

  logic [TIME_W:0] full;

  // A clear borrow bit means a is at least b.
  assign full     = {1'b0, a} - {1'b0, b};
  assign res.ge   = ~full[TIME_W];
  assign res.diff = full[TIME_W-1:0];

endmodule
`default_nettype wire

/* design/epoch_seconds_to_calendar_core.sv */
// Epoch-seconds to calendar converter, top level. Depends on esc_pkg and esc_sub_unit.
// Busy stays high until the result shows, so a new conversion is taken only after the
// last one is through; every phase uses the single shared 32-bit compare-and-subtract unit.
// Reset (rst_n low, synchronous) idles the sequencer and loads the zone offset with 10800.
`default_nettype none
module epoch_seconds_to_calendar_core
  import esc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Command channel
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [TIME_W-1:0]   in_epoch_seconds,
  // Result channel, one cycle strobe, cannot be held off
  output logic                     out_valid,
  output logic [4:0]               out_century,
  output logic [6:0]               out_year_in_century,
  output logic [3:0]               out_month,
  output logic [4:0]               out_day_of_month,
  output logic [4:0]               out_hour,
  output logic [5:0]               out_minute,
  output logic [5:0]               out_second,
  // Configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  // ---------------------------------------------------------------------------
  // Configuration register. The register index is the word address, bit 2 of
  // the byte address; a write to any other index is dropped.
  // ---------------------------------------------------------------------------
  logic [OFFSET_W-1:0] zone_r;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= OFFSET_RESET;
    end else if (cfg_write && paddr[2] == REG_ZONE_OFFSET) begin
      zone_r <= pwdata[OFFSET_W-1:0];
    end
  end

  // Reads return the offset sign-extended to the bus width.
  always_comb begin
    if (paddr[2] == REG_ZONE_OFFSET) begin
      prdata = {{(32 - OFFSET_W){zone_r[OFFSET_W-1]}}, zone_r};
    end else begin
      prdata = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state. The working count t_r shrinks as whole years, then whole
  // months are subtracted; days, hours and minutes then come out of three
  // restoring divisions that share the same subtractor, one quotient bit per
  // cycle starting with the divisor shifted left by step_r.
  // ---------------------------------------------------------------------------
  esc_state_t        state_r, state_nxt;
  logic [TIME_W-1:0] t_r, t_nxt;
  logic [4:0]        century_r, century_nxt;
  logic [6:0]        yy_r, yy_nxt;
  logic [3:0]        mon_r, mon_nxt;
  logic [2:0]        step_r, step_nxt;
  logic [5:0]        quot_r, quot_nxt;
  logic [4:0]        day_r, day_nxt;
  logic [4:0]        hour_r, hour_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;
  logic [5:0]        minute_nxt, second_nxt;

  logic [TIME_W-1:0] operand;
  logic              leap;
  logic [5:0]        quot_shift;
  esc_sub_t          sub;

  // The leap rule looks only at the two-digit year.
  assign leap       = (yy_r[1:0] == 2'b00);
  assign quot_shift = {quot_r[4:0], sub.ge};

  // Operand of the shared unit for the current phase.
  always_comb begin
    unique case (state_r)
      ESC_YEAR:  operand = leap ? YEAR366_SECS : YEAR365_SECS;
      ESC_MONTH: operand = month_span(mon_r, leap);
      ESC_DAY:   operand = DAY_SECS << step_r;
      ESC_HOUR:  operand = HOUR_SECS << step_r;
      ESC_MIN:   operand = MIN_SECS << step_r;
      default:   operand = '0;
    endcase
  end

  esc_sub_unit u_sub (
    .a   (t_r),
    .b   (operand),
    .res (sub)
  );

  assign busy = (state_r != ESC_IDLE);

  always_comb begin
    state_nxt     = state_r;
    t_nxt         = t_r;
    century_nxt   = century_r;
    yy_nxt        = yy_r;
    mon_nxt       = mon_r;
    step_nxt      = step_r;
    quot_nxt      = quot_r;
    day_nxt       = day_r;
    hour_nxt      = hour_r;
    out_valid_nxt = 1'b0;
    out_load      = 1'b0;
    minute_nxt    = quot_shift;
    second_nxt    = sub.ge ? sub.diff[5:0] : t_r[5:0];

    unique case (state_r)
      ESC_IDLE: begin
        if (start) begin
          // The sum wraps modulo 2^32 by truncation.
          t_nxt       = in_epoch_seconds
                        + {{(TIME_W - OFFSET_W){zone_r[OFFSET_W-1]}}, zone_r};
          century_nxt = 5'd19;
          yy_nxt      = 7'd70;
          mon_nxt     = 4'd1;
          state_nxt   = ESC_YEAR;
        end
      end
      ESC_YEAR: begin
        // A remainder equal to a full year rolls into the next year.
        if (sub.ge) begin
          t_nxt = sub.diff;
          if (yy_r == 7'd99) begin
            yy_nxt      = 7'd0;
            century_nxt = century_r + 5'd1;
          end else begin
            yy_nxt = yy_r + 7'd1;
          end
        end else begin
          state_nxt = ESC_MONTH;
        end
      end
      ESC_MONTH: begin
        // December absorbs whatever is left of the year.
        if (sub.ge && mon_r < 4'd12) begin
          t_nxt   = sub.diff;
          mon_nxt = mon_r + 4'd1;
        end else begin
          state_nxt = ESC_DAY;
          step_nxt  = 3'd4;
          quot_nxt  = '0;
        end
      end
      ESC_DAY: begin
        if (sub.ge) begin
          t_nxt = sub.diff;
        end
        quot_nxt = quot_shift;
        step_nxt = step_r - 3'd1;
        if (step_r == 3'd0) begin
          day_nxt   = quot_shift[4:0] + 5'd1;
          quot_nxt  = '0;
          step_nxt  = 3'd4;
          state_nxt = ESC_HOUR;
        end
      end
      ESC_HOUR: begin
        if (sub.ge) begin
          t_nxt = sub.diff;
        end
        quot_nxt = quot_shift;
        step_nxt = step_r - 3'd1;
        if (step_r == 3'd0) begin
          hour_nxt  = quot_shift[4:0];
          quot_nxt  = '0;
          step_nxt  = 3'd5;
          state_nxt = ESC_MIN;
        end
      end
      ESC_MIN: begin
        if (sub.ge) begin
          t_nxt = sub.diff;
        end
        quot_nxt = quot_shift;
        step_nxt = step_r - 3'd1;
        if (step_r == 3'd0) begin
          // Last quotient bit gives the minute; what remains is the second.
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ESC_IDLE;
        end
      end
      default: begin
        state_nxt = ESC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ESC_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    century_r <= century_nxt;
    yy_r      <= yy_nxt;
    mon_r     <= mon_nxt;
    step_r    <= step_nxt;
    quot_r    <= quot_nxt;
    day_r     <= day_nxt;
    hour_r    <= hour_nxt;
  end

  // Result registers hold the last result so the sequencer may start anew
  // in the very cycle the strobe is shown.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_century         <= century_r;
      out_year_in_century <= yy_r;
      out_month           <= mon_r;
      out_day_of_month    <= day_r;
      out_hour            <= hour_r;
      out_minute          <= minute_nxt;
      out_second          <= second_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* design/esc_checker.sv */
// Port-level checker for the calendar converter and its bind to the top level.
// Depends on esc_pkg and epoch_seconds_to_calendar_core.
`default_nettype none
module esc_checker
  import esc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [3:0] out_month,
  input wire logic [4:0] out_century
);

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe outside the end of a conversion");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_month != 4'd0 && out_month <= 4'd12)
    else $error("month out of range");

  a_century_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_century == 5'd19 || out_century == 5'd20 || out_century == 5'd21)
    else $error("century out of range");

endmodule

bind epoch_seconds_to_calendar_core esc_checker u_esc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_month   (out_month),
  .out_century (out_century)
);
`default_nettype wire
